### hw/rtl/csv_pkg.sv
// csv_pkg: shared types, constants and the step micro-op table for the
// coupled spring Verlet stepper. No dependencies.
`default_nettype none
package csv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int Q_W           = 32;
  localparam int CFG_W         = 31;
  localparam int DT_W          = 16;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // input command codes
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRING_FIRST      = 3'd0,
    CFG_SPRING_SECOND     = 3'd1,
    CFG_COUPLING_SPRING   = 3'd2,
    CFG_RECIP_MASS_FIRST  = 3'd3,
    CFG_RECIP_MASS_SECOND = 3'd4,
    CFG_TIME_STEP         = 3'd5
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] CFG_ONE_RST = CFG_W'(65536);
  localparam logic [DT_W-1:0]  CFG_DT_RST  = DT_W'(655);

  typedef struct packed {
    logic [CFG_W-1:0] k1;
    logic [CFG_W-1:0] k2;
    logic [CFG_W-1:0] kc;
    logic [CFG_W-1:0] rm1;
    logic [CFG_W-1:0] rm2;
    logic [DT_W-1:0]  dt;
  } cfg_regs_t;

  // operand sources; A1H/A2H are the accel registers halved
  typedef enum logic [4:0] {
    SRC_X1, SRC_V1, SRC_X2, SRC_V2, SRC_DT, SRC_DT2, SRC_KC, SRC_KS1, SRC_KS2,
    SRC_RM1, SRC_RM2, SRC_P1, SRC_P2, SRC_S1, SRC_S2, SRC_A1, SRC_A2,
    SRC_A1H, SRC_A2H, SRC_U1, SRC_U2
  } src_t;

  typedef enum logic [3:0] {
    DST_X1, DST_V1, DST_X2, DST_V2, DST_DT2, DST_P1, DST_P2, DST_S1, DST_S2,
    DST_A1, DST_A2, DST_U1, DST_U2
  } dst_t;

  // writeback: dst = q, dst = clip(t + q), dst = clip(t - q)
  typedef enum logic [1:0] {POST_NONE, POST_ADD, POST_SUB} post_t;

  typedef struct packed {
    src_t  a;
    src_t  b;
    dst_t  dst;
    post_t post;
    src_t  t;
  } uop_t;

  localparam int NUM_UOPS  = 19;
  localparam int UOP_IDX_W = $clog2(NUM_UOPS);

  typedef struct packed {
    logic                 load;
    logic                 ksum;
    logic                 issue;
    logic [UOP_IDX_W-1:0] op_idx;
    logic                 publish;
  } dp_cmd_t;

  // Consecutive ops never depend on each other: an op's result lands in the
  // cycle after the next op has read its operands.
  function automatic uop_t uop_rom(input logic [UOP_IDX_W-1:0] idx);
    uop_t u;
    u = '{a: SRC_DT, b: SRC_DT, dst: DST_DT2, post: POST_NONE, t: SRC_X1};
    case (idx)
      5'd0:  u = '{a: SRC_DT,  b: SRC_DT,  dst: DST_DT2, post: POST_NONE, t: SRC_X1};
      5'd1:  u = '{a: SRC_KC,  b: SRC_X2,  dst: DST_P1,  post: POST_NONE, t: SRC_X1};
      5'd2:  u = '{a: SRC_KC,  b: SRC_X1,  dst: DST_P2,  post: POST_NONE, t: SRC_X1};
      5'd3:  u = '{a: SRC_KS1, b: SRC_X1,  dst: DST_S1,  post: POST_SUB,  t: SRC_P1};
      5'd4:  u = '{a: SRC_KS2, b: SRC_X2,  dst: DST_S2,  post: POST_SUB,  t: SRC_P2};
      5'd5:  u = '{a: SRC_S1,  b: SRC_RM1, dst: DST_A1,  post: POST_NONE, t: SRC_X1};
      5'd6:  u = '{a: SRC_S2,  b: SRC_RM2, dst: DST_A2,  post: POST_NONE, t: SRC_X1};
      5'd7:  u = '{a: SRC_V1,  b: SRC_DT,  dst: DST_U1,  post: POST_ADD,  t: SRC_X1};
      5'd8:  u = '{a: SRC_V2,  b: SRC_DT,  dst: DST_U2,  post: POST_ADD,  t: SRC_X2};
      5'd9:  u = '{a: SRC_A1H, b: SRC_DT2, dst: DST_X1,  post: POST_ADD,  t: SRC_U1};
      5'd10: u = '{a: SRC_A2H, b: SRC_DT2, dst: DST_X2,  post: POST_ADD,  t: SRC_U2};
      5'd11: u = '{a: SRC_KC,  b: SRC_X1,  dst: DST_P2,  post: POST_NONE, t: SRC_X1};
      5'd12: u = '{a: SRC_KC,  b: SRC_X2,  dst: DST_P1,  post: POST_NONE, t: SRC_X1};
      5'd13: u = '{a: SRC_KS2, b: SRC_X2,  dst: DST_S2,  post: POST_SUB,  t: SRC_P2};
      5'd14: u = '{a: SRC_KS1, b: SRC_X1,  dst: DST_S1,  post: POST_SUB,  t: SRC_P1};
      5'd15: u = '{a: SRC_S2,  b: SRC_RM2, dst: DST_A2,  post: POST_ADD,  t: SRC_A2};
      5'd16: u = '{a: SRC_S1,  b: SRC_RM1, dst: DST_A1,  post: POST_ADD,  t: SRC_A1};
      5'd17: u = '{a: SRC_A2H, b: SRC_DT,  dst: DST_V2,  post: POST_ADD,  t: SRC_V2};
      5'd18: u = '{a: SRC_A1H, b: SRC_DT,  dst: DST_V1,  post: POST_ADD,  t: SRC_V1};
      default: u = '{a: SRC_DT, b: SRC_DT, dst: DST_DT2, post: POST_NONE, t: SRC_X1};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/coupled_spring_verlet_step.sv
// coupled_spring_verlet_step: top level of the two-mass velocity Verlet
// stepper. Depends on csv_pkg, csv_cfg, csv_ctrl and csv_dp.
//
//   channel   handshake               payload
//   --------  ----------------------  -------------------------------------
//   cfg       cfg_we                  cfg_index, cfg_wdata
//   in        in_valid / in_ready     in_cmd, in_load_{pos,vel}_{first,second}
//   out       out_valid / out_ready   out_{pos,vel}_{first,second},
//                                     out_step_count, out_saturated
//
// A step beat runs the spring sums, 19 micro-op issues on the single
// shared 32x32 multiplier, a writeback drain and the publish; a load beat
// goes straight to the publish. The next beat can be accepted in the cycle
// after the publish. A new beat is accepted once the previous result
// sits in the output register, even if that beat is not yet taken; a
// still-held result stalls the next publish.
// Reset is synchronous, active low, and zeroes the state and step counter.
`default_nettype none
module coupled_spring_verlet_step #(
  parameter int FRAC_BITS = csv_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // configuration writes
  input  wire                              cfg_we,
  input  wire  [csv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [csv_pkg::CFG_W-1:0]        cfg_wdata,
  // input beats
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_cmd,
  input  wire  signed [31:0]               in_load_pos_first,
  input  wire  signed [31:0]               in_load_vel_first,
  input  wire  signed [31:0]               in_load_pos_second,
  input  wire  signed [31:0]               in_load_vel_second,
  // result beats
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [31:0]               out_pos_first,
  output logic signed [31:0]               out_vel_first,
  output logic signed [31:0]               out_pos_second,
  output logic signed [31:0]               out_vel_second,
  output logic        [31:0]               out_step_count,
  output logic                             out_saturated
);

  csv_pkg::cfg_regs_t cfg;
  csv_pkg::dp_cmd_t   cmd;

  // the user must write config only while idle (the block does not enforce it), so the datapath reads it live
  csv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sequencer: IDLE -> KSUM -> ISSUE x19 -> DRAIN -> PUB, load skips to PUB
  csv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  csv_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .in_load_pos_first  (in_load_pos_first),
    .in_load_vel_first  (in_load_vel_first),
    .in_load_pos_second (in_load_pos_second),
    .in_load_vel_second (in_load_vel_second),
    .out_pos_first      (out_pos_first),
    .out_vel_first      (out_vel_first),
    .out_pos_second     (out_pos_second),
    .out_vel_second     (out_vel_second),
    .out_step_count     (out_step_count),
    .out_saturated      (out_saturated)
  );

endmodule
`default_nettype wire

### hw/rtl/csv_cfg.sv
// csv_cfg: configuration register file (springs, reciprocal masses, dt).
// Depends on csv_pkg.
`default_nettype none
module csv_cfg (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [csv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [csv_pkg::CFG_W-1:0]          cfg_wdata,
  output csv_pkg::cfg_regs_t                 cfg
);

  csv_pkg::cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        csv_pkg::CFG_SPRING_FIRST:      cfg_nxt.k1  = cfg_wdata;
        csv_pkg::CFG_SPRING_SECOND:     cfg_nxt.k2  = cfg_wdata;
        csv_pkg::CFG_COUPLING_SPRING:   cfg_nxt.kc  = cfg_wdata;
        csv_pkg::CFG_RECIP_MASS_FIRST:  cfg_nxt.rm1 = cfg_wdata;
        csv_pkg::CFG_RECIP_MASS_SECOND: cfg_nxt.rm2 = cfg_wdata;
        csv_pkg::CFG_TIME_STEP:         cfg_nxt.dt  = cfg_wdata[csv_pkg::DT_W-1:0];
        default:                        cfg_nxt = cfg_r; // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k1  <= csv_pkg::CFG_ONE_RST;
      cfg_r.k2  <= csv_pkg::CFG_ONE_RST;
      cfg_r.kc  <= csv_pkg::CFG_ONE_RST;
      cfg_r.rm1 <= csv_pkg::CFG_ONE_RST;
      cfg_r.rm2 <= csv_pkg::CFG_ONE_RST;
      cfg_r.dt  <= csv_pkg::CFG_DT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### hw/rtl/csv_ctrl.sv
// csv_ctrl: sequencer for the stepper; walks the micro-op table and
// handles both handshakes. Depends on csv_pkg.
`default_nettype none
module csv_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_cmd,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  output csv_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_KSUM  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_DRAIN = 5'b01000,
    S_PUB   = 5'b10000
  } state_t;

  localparam logic [csv_pkg::UOP_IDX_W-1:0] LAST_OP =
    csv_pkg::UOP_IDX_W'(csv_pkg::NUM_UOPS - 1);

  state_t                        state_r, state_nxt;
  logic [csv_pkg::UOP_IDX_W-1:0] op_idx_r, op_idx_nxt;
  logic                          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_idx_nxt    = op_idx_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.op_idx    = op_idx_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == csv_pkg::CMD_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = S_PUB;
          end else begin
            state_nxt = S_KSUM;
          end
        end
      end
      S_KSUM: begin
        cmd.ksum   = 1'b1;
        op_idx_nxt = '0;
        state_nxt  = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (op_idx_r == LAST_OP) begin
          state_nxt = S_DRAIN;
        end else begin
          op_idx_nxt = op_idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PUB;
      end
      S_PUB: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_idx_r    <= op_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_pub_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result published over a held beat");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (op_idx_r <= LAST_OP))
    else $error("micro-op index past end of table");

  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == csv_pkg::CMD_STEP) |=> (state_r == S_KSUM))
    else $error("accepted step beat did not start the sequence");

  a_valid_from_pub: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUB))
    else $error("result valid raised outside publish");
`endif

endmodule
`default_nettype wire

### hw/rtl/csv_dp.sv
// csv_dp: datapath with state, scratch registers, one shared 32x32
// multiplier and the shift/clip/add/sub writeback. Depends on csv_pkg.
`default_nettype none
module csv_dp #(
  parameter int FRAC_BITS = csv_pkg::FRAC_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  csv_pkg::cfg_regs_t       cfg,
  input  csv_pkg::dp_cmd_t         cmd,
  input  wire  signed [31:0]       in_load_pos_first,
  input  wire  signed [31:0]       in_load_vel_first,
  input  wire  signed [31:0]       in_load_pos_second,
  input  wire  signed [31:0]       in_load_vel_second,
  output logic signed [31:0]       out_pos_first,
  output logic signed [31:0]       out_vel_first,
  output logic signed [31:0]       out_pos_second,
  output logic signed [31:0]       out_vel_second,
  output logic        [31:0]       out_step_count,
  output logic                     out_saturated
);

  localparam int QW = csv_pkg::Q_W;

  // architectural state
  csv_pkg::q_t x1_r, x1_nxt, v1_r, v1_nxt, x2_r, x2_nxt, v2_r, v2_nxt;
  logic [QW-1:0] steps_r, steps_nxt;
  logic          sat_r, sat_nxt;
  // scratch
  csv_pkg::q_t dt2_r, dt2_nxt, p1_r, p1_nxt, p2_r, p2_nxt, s1_r, s1_nxt;
  csv_pkg::q_t s2_r, s2_nxt, a1_r, a1_nxt, a2_r, a2_nxt, u1_r, u1_nxt;
  csv_pkg::q_t u2_r, u2_nxt, ks1_r, ks1_nxt, ks2_r, ks2_nxt;
  // multiplier stage
  logic signed [2*QW-1:0] prod_r, prod_nxt;
  csv_pkg::uop_t          wb_op_r, wb_op_nxt;
  logic                   wb_valid_r, wb_valid_nxt;
  // result beat
  csv_pkg::q_t   opx1_r, opx1_nxt, opv1_r, opv1_nxt, opx2_r, opx2_nxt;
  csv_pkg::q_t   opv2_r, opv2_nxt;
  logic [QW-1:0] ostep_r, ostep_nxt;
  logic          osat_r, osat_nxt;

  csv_pkg::uop_t          iss_op;
  csv_pkg::q_t            opa, opb, opt, q_val, wb_val;
  logic signed [2*QW-1:0] shifted;
  logic signed [QW:0]     wide_sum;
  logic                   q_clip, sum_clip, ks1_clip, ks2_clip;
  logic [QW-1:0]          ks1_raw, ks2_raw;

  function automatic csv_pkg::q_t pick(input csv_pkg::src_t s);
    csv_pkg::q_t v;
    case (s)
      csv_pkg::SRC_X1:  v = x1_r;
      csv_pkg::SRC_V1:  v = v1_r;
      csv_pkg::SRC_X2:  v = x2_r;
      csv_pkg::SRC_V2:  v = v2_r;
      csv_pkg::SRC_DT:  v = $signed({{(QW-csv_pkg::DT_W){1'b0}}, cfg.dt});
      csv_pkg::SRC_DT2: v = dt2_r;
      csv_pkg::SRC_KC:  v = $signed({1'b0, cfg.kc});
      csv_pkg::SRC_KS1: v = ks1_r;
      csv_pkg::SRC_KS2: v = ks2_r;
      csv_pkg::SRC_RM1: v = $signed({1'b0, cfg.rm1});
      csv_pkg::SRC_RM2: v = $signed({1'b0, cfg.rm2});
      csv_pkg::SRC_P1:  v = p1_r;
      csv_pkg::SRC_P2:  v = p2_r;
      csv_pkg::SRC_S1:  v = s1_r;
      csv_pkg::SRC_S2:  v = s2_r;
      csv_pkg::SRC_A1:  v = a1_r;
      csv_pkg::SRC_A2:  v = a2_r;
      // 0.5 * a, rounded down: floor(a / 2)
      csv_pkg::SRC_A1H: v = a1_r >>> 1;
      csv_pkg::SRC_A2H: v = a2_r >>> 1;
      csv_pkg::SRC_U1:  v = u1_r;
      csv_pkg::SRC_U2:  v = u2_r;
      default:          v = '0;
    endcase
    return v;
  endfunction

  // operand fetch and the shared multiplier
  always_comb begin
    iss_op   = csv_pkg::uop_rom(cmd.op_idx);
    opa      = pick(iss_op.a);
    opb      = pick(iss_op.b);
    prod_nxt = opa * opb;
  end

  // writeback: floor shift, clip, optional add/sub with clip
  always_comb begin
    shifted = prod_r >>> FRAC_BITS;
    q_clip  = (shifted[2*QW-1:QW-1] != {(QW+1){shifted[2*QW-1]}});
    if (q_clip) begin
      q_val = shifted[2*QW-1] ? csv_pkg::Q_MIN : csv_pkg::Q_MAX;
    end else begin
      q_val = shifted[QW-1:0];
    end
    opt = pick(wb_op_r.t);
    case (wb_op_r.post)
      csv_pkg::POST_ADD: wide_sum = {opt[QW-1], opt} + {q_val[QW-1], q_val};
      csv_pkg::POST_SUB: wide_sum = {opt[QW-1], opt} - {q_val[QW-1], q_val};
      default:           wide_sum = {q_val[QW-1], q_val};
    endcase
    sum_clip = (wide_sum[QW] != wide_sum[QW-1]);
    if (sum_clip) begin
      wb_val = wide_sum[QW] ? csv_pkg::Q_MIN : csv_pkg::Q_MAX;
    end else begin
      wb_val = wide_sum[QW-1:0];
    end
  end

  // k_own + k_c, both below 2^31
  assign ks1_raw  = {1'b0, cfg.k1} + {1'b0, cfg.kc};
  assign ks2_raw  = {1'b0, cfg.k2} + {1'b0, cfg.kc};
  assign ks1_clip = ks1_raw[QW-1];
  assign ks2_clip = ks2_raw[QW-1];

  always_comb begin
    x1_nxt = x1_r;  v1_nxt = v1_r;  x2_nxt = x2_r;  v2_nxt = v2_r;
    steps_nxt = steps_r;  sat_nxt = sat_r;
    dt2_nxt = dt2_r;  p1_nxt = p1_r;  p2_nxt = p2_r;  s1_nxt = s1_r;
    s2_nxt = s2_r;  a1_nxt = a1_r;  a2_nxt = a2_r;  u1_nxt = u1_r;
    u2_nxt = u2_r;  ks1_nxt = ks1_r;  ks2_nxt = ks2_r;
    wb_op_nxt    = wb_op_r;
    wb_valid_nxt = 1'b0;
    opx1_nxt = opx1_r;  opv1_nxt = opv1_r;  opx2_nxt = opx2_r;
    opv2_nxt = opv2_r;  ostep_nxt = ostep_r;  osat_nxt = osat_r;

    if (cmd.load) begin
      x1_nxt    = in_load_pos_first;
      v1_nxt    = in_load_vel_first;
      x2_nxt    = in_load_pos_second;
      v2_nxt    = in_load_vel_second;
      steps_nxt = '0;
      sat_nxt   = 1'b0;
    end

    if (cmd.ksum) begin
      ks1_nxt   = ks1_clip ? csv_pkg::Q_MAX : $signed(ks1_raw);
      ks2_nxt   = ks2_clip ? csv_pkg::Q_MAX : $signed(ks2_raw);
      sat_nxt   = ks1_clip | ks2_clip;
      steps_nxt = steps_r + 1'b1;
    end

    if (cmd.issue) begin
      wb_op_nxt    = iss_op;
      wb_valid_nxt = 1'b1;
    end

    if (wb_valid_r) begin
      sat_nxt = sat_r | q_clip | sum_clip;
      case (wb_op_r.dst)
        csv_pkg::DST_X1:  x1_nxt  = wb_val;
        csv_pkg::DST_V1:  v1_nxt  = wb_val;
        csv_pkg::DST_X2:  x2_nxt  = wb_val;
        csv_pkg::DST_V2:  v2_nxt  = wb_val;
        csv_pkg::DST_DT2: dt2_nxt = wb_val;
        csv_pkg::DST_P1:  p1_nxt  = wb_val;
        csv_pkg::DST_P2:  p2_nxt  = wb_val;
        csv_pkg::DST_S1:  s1_nxt  = wb_val;
        csv_pkg::DST_S2:  s2_nxt  = wb_val;
        csv_pkg::DST_A1:  a1_nxt  = wb_val;
        csv_pkg::DST_A2:  a2_nxt  = wb_val;
        csv_pkg::DST_U1:  u1_nxt  = wb_val;
        csv_pkg::DST_U2:  u2_nxt  = wb_val;
        default:          dt2_nxt = dt2_r;
      endcase
    end

    if (cmd.publish) begin
      opx1_nxt  = x1_r;
      opv1_nxt  = v1_r;
      opx2_nxt  = x2_r;
      opv2_nxt  = v2_r;
      ostep_nxt = steps_r;
      osat_nxt  = sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r       <= '0;
      v1_r       <= '0;
      x2_r       <= '0;
      v2_r       <= '0;
      steps_r    <= '0;
      sat_r      <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      x1_r       <= x1_nxt;
      v1_r       <= v1_nxt;
      x2_r       <= x2_nxt;
      v2_r       <= v2_nxt;
      steps_r    <= steps_nxt;
      sat_r      <= sat_nxt;
      wb_valid_r <= wb_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt2_r   <= dt2_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    s1_r    <= s1_nxt;
    s2_r    <= s2_nxt;
    a1_r    <= a1_nxt;
    a2_r    <= a2_nxt;
    u1_r    <= u1_nxt;
    u2_r    <= u2_nxt;
    ks1_r   <= ks1_nxt;
    ks2_r   <= ks2_nxt;
    prod_r  <= prod_nxt;
    wb_op_r <= wb_op_nxt;
    opx1_r  <= opx1_nxt;
    opv1_r  <= opv1_nxt;
    opx2_r  <= opx2_nxt;
    opv2_r  <= opv2_nxt;
    ostep_r <= ostep_nxt;
    osat_r  <= osat_nxt;
  end

  assign out_pos_first  = opx1_r;
  assign out_vel_first  = opv1_r;
  assign out_pos_second = opx2_r;
  assign out_vel_second = opv2_r;
  assign out_step_count = ostep_r;
  assign out_saturated  = osat_r;

endmodule
`default_nettype wire

### tb/coupled_spring_verlet_step_test.sv
// coupled_spring_verlet_step_test: self-checking bench for the two-mass Verlet stepper.
// Depends on csv_pkg and coupled_spring_verlet_step; drives cfg/in, scoreboards out.
// Expected beats come from a 64-bit fixed-point predictor kept in lockstep with the DUT.
`default_nettype none
module coupled_spring_verlet_step_test;
  import csv_pkg::*;

  // Unused register slots; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  localparam longint HALF_L = longint'(1) << (FRAC_BITS_DEF - 1);

  // one result beat, field for field
  typedef struct packed {
    q_t          pos_first;
    q_t          vel_first;
    q_t          pos_second;
    q_t          vel_second;
    logic [31:0] step_count;
    logic        saturated;
  } mass_state_t;

  // ---------------------------------------------------------------------------
  // clock, reset, DUT pins (every input known from time zero)
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_STEP;
  q_t                   in_load_pos_first = '0;
  q_t                   in_load_vel_first = '0;
  q_t                   in_load_pos_second = '0;
  q_t                   in_load_vel_second = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  q_t                   out_pos_first;
  q_t                   out_vel_first;
  q_t                   out_pos_second;
  q_t                   out_vel_second;
  logic [31:0]          out_step_count;
  logic                 out_saturated;

  always #5 clk = ~clk;

  coupled_spring_verlet_step u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_load_pos_first  (in_load_pos_first),
    .in_load_vel_first  (in_load_vel_first),
    .in_load_pos_second (in_load_pos_second),
    .in_load_vel_second (in_load_vel_second),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pos_first      (out_pos_first),
    .out_vel_first      (out_vel_first),
    .out_pos_second     (out_pos_second),
    .out_vel_second     (out_vel_second),
    .out_step_count     (out_step_count),
    .out_saturated      (out_saturated)
  );

  // ---------------------------------------------------------------------------
  // predictor: shadow registers and mass state, updated on each accepted beat
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] k_wall_a   = CFG_ONE_RST;
  logic [CFG_W-1:0] k_wall_b   = CFG_ONE_RST;
  logic [CFG_W-1:0] k_mid      = CFG_ONE_RST;
  logic [CFG_W-1:0] inv_mass_a = CFG_ONE_RST;
  logic [CFG_W-1:0] inv_mass_b = CFG_ONE_RST;
  logic [DT_W-1:0]  dt_q       = CFG_DT_RST;
  q_t               x_a = '0, v_a = '0, x_b = '0, v_b = '0;
  logic [31:0]      step_total = '0;
  bit               clip_hit;

  mass_state_t expected_states[$];

  int send_idle_pct = 28;   // sender gap chance per cycle, percent
  int recv_idle_pct = 71;   // receiver stall chance per cycle, percent
  int recv_hold     = 0;    // forced receiver stall, cycles left
  int items_sent    = 0;
  int fail_count    = 0;

  // saturate to 32-bit signed, remembering that a clip happened this beat
  function automatic longint sat32(input longint v);
    if (v > longint'(Q_MAX)) begin
      clip_hit = 1'b1;
      return longint'(Q_MAX);
    end
    if (v < longint'(Q_MIN)) begin
      clip_hit = 1'b1;
      return longint'(Q_MIN);
    end
    return v;
  endfunction

  // Qm.n multiply; >>> on a signed product rounds toward minus infinity
  function automatic longint fxmul(input longint a, input longint b);
    return sat32((a * b) >>> FRAC_BITS_DEF);
  endfunction

  // (kc * x_other - (k_own + kc) * x_own) / m
  function automatic longint spring_accel(input longint x_own, input longint x_other,
                                          input longint k_own, input longint inv_m);
    longint ksum;
    ksum = sat32(k_own + longint'(k_mid));
    return fxmul(sat32(fxmul(longint'(k_mid), x_other) - fxmul(ksum, x_own)), inv_m);
  endfunction

  // One velocity Verlet step (or a load); returns the beat the DUT must emit.
  function automatic mass_state_t step_masses(input logic cmd, input q_t lp1, input q_t lv1,
                                              input q_t lp2, input q_t lv2);
    longint x1, v1, x2, v2, dt, dt2, a1, a2, n1, n2, b1, b2;
    mass_state_t r;
    clip_hit = 1'b0;
    if (cmd == CMD_LOAD) begin
      x_a = lp1;
      v_a = lv1;
      x_b = lp2;
      v_b = lv2;
      step_total = '0;
    end else begin
      x1  = x_a;
      v1  = v_a;
      x2  = x_b;
      v2  = v_b;
      dt  = longint'(dt_q);
      dt2 = fxmul(dt, dt);
      a1  = spring_accel(x1, x2, longint'(k_wall_a), longint'(inv_mass_a));
      a2  = spring_accel(x2, x1, longint'(k_wall_b), longint'(inv_mass_b));
      // positions first, from the old accelerations
      n1  = sat32(sat32(x1 + fxmul(v1, dt)) + fxmul(fxmul(HALF_L, a1), dt2));
      n2  = sat32(sat32(x2 + fxmul(v2, dt)) + fxmul(fxmul(HALF_L, a2), dt2));
      // then velocities, from the mean of old and new accelerations
      b1  = spring_accel(n1, n2, longint'(k_wall_a), longint'(inv_mass_a));
      b2  = spring_accel(n2, n1, longint'(k_wall_b), longint'(inv_mass_b));
      v1  = sat32(v1 + fxmul(fxmul(HALF_L, sat32(a1 + b1)), dt));
      v2  = sat32(v2 + fxmul(fxmul(HALF_L, sat32(a2 + b2)), dt));
      x_a = q_t'(n1);
      x_b = q_t'(n2);
      v_a = q_t'(v1);
      v_b = q_t'(v2);
      step_total = step_total + 32'd1;   // wraps like the DUT counter
    end
    r.pos_first  = x_a;
    r.vel_first  = v_a;
    r.pos_second = x_b;
    r.vel_second = v_b;
    r.step_count = step_total;
    r.saturated  = clip_hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold = recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic compare_field(input string name, input longint exp_v, input longint got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // Scoreboard: sampled at the rising edge, before the DUT's updates land.
  always @(posedge clk) begin
    mass_state_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_states.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with nothing pending, expected none, got pos_first %0d",
                 $time, out_pos_first);
      end else begin
        e = expected_states.pop_front();
        compare_field("pos_first",  e.pos_first,  out_pos_first);
        compare_field("vel_first",  e.vel_first,  out_vel_first);
        compare_field("pos_second", e.pos_second, out_pos_second);
        compare_field("vel_second", e.vel_second, out_vel_second);
        compare_field("step_count", e.step_count, out_step_count);
        compare_field("saturated",  e.saturated,  out_saturated);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one beat, hold it until taken, then predict. Returns at the accept edge;
  // valid stays up so back-to-back beats need no drop.
  task automatic send_beat(input logic cmd, input q_t p1, input q_t v1,
                           input q_t p2, input q_t v2);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_cmd             = cmd;
    in_load_pos_first  = p1;
    in_load_vel_first  = v1;
    in_load_pos_second = p2;
    in_load_vel_second = v2;
    do @(posedge clk); while (!in_ready);
    expected_states.push_back(step_masses(cmd, p1, v1, p2, v2));
    items_sent++;
  endtask

  // Drop valid and wait for every pending beat; the DUT is idle afterwards
  // since each beat yields exactly one result.
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_states.size() != 0) @(negedge clk);
  endtask

  // Register write; only called with the block settled.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      CFG_SPRING_FIRST:      k_wall_a   = val;
      CFG_SPRING_SECOND:     k_wall_b   = val;
      CFG_COUPLING_SPRING:   k_mid      = val;
      CFG_RECIP_MASS_FIRST:  inv_mass_a = val;
      CFG_RECIP_MASS_SECOND: inv_mass_b = val;
      CFG_TIME_STEP:         dt_q       = val[DT_W-1:0];
      default: ;             // spare index, dropped
    endcase
  endtask

  task automatic write_all_regs(input logic [CFG_W-1:0] val);
    cfg_idx_t r;
    r = r.first();
    repeat (r.num()) begin
      write_reg(r, val);
      r = r.next();
    end
  endtask

  // Mostly physical values so runs stay in range; sometimes an edge or raw bits.
  function automatic logic [CFG_W-1:0] rand_cfg_value(input cfg_idx_t r);
    bit is_dt, is_inv;
    int pick;
    is_dt  = (r == CFG_TIME_STEP);
    is_inv = (r == CFG_RECIP_MASS_FIRST) || (r == CFG_RECIP_MASS_SECOND);
    pick   = $urandom_range(11);
    if (pick == 0)      return (is_dt || is_inv) ? CFG_W'(1) : '0;
    else if (pick == 1) return is_dt ? CFG_W'({DT_W{1'b1}}) : '1;
    else if (pick == 2) return CFG_W'($urandom());      // upper bits exercise dt masking
    else if (is_dt)     return CFG_W'($urandom_range(6554, 16));
    else if (is_inv)    return CFG_W'($urandom_range(1 << 18, 1 << 14));
    else                return CFG_W'($urandom_range(1 << 19, 1 << 10));
  endfunction

  task automatic program_random_regs();
    cfg_idx_t r;
    r = r.first();
    repeat (r.num()) begin
      write_reg(r, rand_cfg_value(r));
      r = r.next();
    end
  endtask

  // wide: full 32-bit range with extra weight on the rails; else within +/-4.0
  function automatic q_t rand_coord(input bit wide);
    int pick;
    if (!wide) return q_t'($urandom_range(1 << 19) - (1 << 18));
    pick = $urandom_range(5);
    if (pick == 0)      return Q_MAX;
    else if (pick == 1) return Q_MIN;
    else                return q_t'($urandom());
  endfunction

  task automatic send_step();
    // load fields carry junk on a step; the DUT must ignore them
    send_beat(CMD_STEP, rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // From reset: zero state stays put, counter counts; then a simple swing.
  task automatic test_reset_state();
    repeat (2) send_step();
    send_beat(CMD_LOAD, q_t'(32'sh0001_0000), '0, q_t'(-32'sh0001_0000), '0);
    repeat (3) send_step();
  endtask

  // Load rails and sign corners, step each: saturation paths and counter clear.
  task automatic test_load_extremes();
    send_beat(CMD_LOAD, Q_MAX, Q_MAX, Q_MIN, Q_MIN);
    send_step();
    send_beat(CMD_LOAD, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
    send_step();
    send_beat(CMD_LOAD, q_t'(-1), '0, q_t'(-1), '0);
    send_step();
    send_beat(CMD_LOAD, '0, q_t'(-1), Q_MAX, q_t'(1));
    send_step();
  endtask

  // Zero springs/masses/dt must freeze motion; all-ones must clip hard.
  // Spare indexes get writes that must not land anywhere.
  task automatic test_register_edges();
    settle_block();
    write_all_regs('0);
    send_beat(CMD_LOAD, q_t'(32'sh0003_0000), q_t'(32'sh0000_8000),
              q_t'(-32'sh0002_0000), q_t'(-32'sh0001_0000));
    repeat (2) send_step();
    settle_block();
    write_all_regs('1);                       // dt sees only its low 16 bits
    write_reg(CFG_IDX_SPARE_LO, '0);
    write_reg(CFG_IDX_SPARE_HI, CFG_W'(12345));
    send_beat(CMD_LOAD, q_t'(32'sh0000_4000), q_t'(-32'sh0000_2000),
              q_t'(-32'sh0000_1000), q_t'(32'sh0000_0800));
    repeat (2) send_step();
    settle_block();
    // back to unit springs and masses, reset dt
    write_all_regs(CFG_ONE_RST);
    write_reg(CFG_TIME_STEP, CFG_W'(CFG_DT_RST));
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and in_ready has to drop.
  task automatic test_backpressure();
    int saved_pct;
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    @(posedge clk);
    recv_hold = 150;
    send_beat(CMD_LOAD, rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0));
    repeat (11) send_step();
    send_idle_pct = saved_pct;
  endtask

  // Mostly well-formed runs (load, then a train of steps) with random
  // registers between runs; the rest is loose noise of either command.
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int beats);
    int goal, kind;
    bit fresh;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal  = items_sent + beats;
    fresh = 1'b1;
    while (items_sent < goal) begin
      if (fresh || $urandom_range(7) == 0) begin
        settle_block();
        program_random_regs();
        fresh = 1'b0;
      end
      kind = $urandom_range(9);
      if (kind < 8) begin
        send_beat(CMD_LOAD, rand_coord(kind == 0), rand_coord(kind == 0),
                  rand_coord(kind == 1), rand_coord(kind == 1));
        repeat ($urandom_range(40, 5)) send_step();
      end else begin
        repeat ($urandom_range(6, 1))
          send_beat($urandom_range(1) ? CMD_LOAD : CMD_STEP, rand_coord(1), rand_coord(1),
                    rand_coord(1), rand_coord(1));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(28, 71, 590);
    run_random_phase(71, 28, 590);
    run_random_phase(0, 0, 590);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_load_extremes();
    test_register_edges();
    test_backpressure();
    test_random_traffic();

    settle_block();
    // leave room after the last step to catch any stray beat
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #6000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
